// ----- design/egnu_pkg.sv -----
// Shared types and constants for the eikonal grid node update core.
package egnu_pkg;

    // Field widths of the node item and the result item
    localparam int TIME_BITS     = 32;
    localparam int INDEX_BITS    = 10;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    // Derived arithmetic widths
    localparam int SUM_BITS  = TIME_BITS + 1;       // a+b or f+min(a,b)
    localparam int PROD_BITS = 2 * TIME_BITS;       // f*f, d*d
    localparam int RAD_BITS  = 2 * TIME_BITS + 2;   // 2f^2-d^2, even width
    localparam int ROOT_BITS = RAD_BITS / 2;        // one root bit per sqrt stage
    localparam int REM_BITS  = ROOT_BITS + 2;       // partial remainder

    // Largest time code, used for an axis with no neighbor and for clipping
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    // Configuration register reset values
    localparam logic [TIME_BITS-1:0]  SLOWNESS_RST = TIME_BITS'(65536);
    localparam logic [INDEX_BITS-1:0] ROW_MAX_RST  = INDEX_BITS'(200);
    localparam logic [INDEX_BITS-1:0] COL_MAX_RST  = INDEX_BITS'(200);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SLOWNESS = 2'd0,
        CFG_ROW_MAX  = 2'd1,
        CFG_COL_MAX  = 2'd2
    } t_cfg_index;

    // Input item
    typedef struct packed {
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        logic [TIME_BITS-1:0]  prev_row_time;
        logic [TIME_BITS-1:0]  next_row_time;
        logic [TIME_BITS-1:0]  prev_col_time;
        logic [TIME_BITS-1:0]  next_col_time;
    } t_node_in;

    // Result item
    typedef struct packed {
        logic [TIME_BITS-1:0] new_time;
        logic                 two_sided;
        logic                 saturated;
    } t_node_out;

    // Axis minima handed from the front to the back through the queue
    typedef struct packed {
        logic [TIME_BITS-1:0] a;
        logic [TIME_BITS-1:0] b;
    } t_axis_pair;

    // Sideband that rides along the square root pipeline
    typedef struct packed {
        logic [SUM_BITS-1:0] base;
        logic                quad;
    } t_side;

endpackage

// ----- design/egnu_front.sv -----
// Front end: accepts node items and reduces the four neighbors to axis minima.
module egnu_front (
    input  logic                               i_start,
    input  logic                               i_full,
    input  egnu_pkg::t_node_in                 i_item,
    input  logic [egnu_pkg::INDEX_BITS-1:0]    i_row_max,
    input  logic [egnu_pkg::INDEX_BITS-1:0]    i_col_max,
    output logic                               o_busy,
    output logic                               o_push,
    output egnu_pkg::t_axis_pair               o_pair
);

    logic [egnu_pkg::TIME_BITS-1:0] row_prev;
    logic [egnu_pkg::TIME_BITS-1:0] col_prev;
    logic [egnu_pkg::TIME_BITS-1:0] row_min;
    logic [egnu_pkg::TIME_BITS-1:0] col_min;

    // Stall the caller only when the queue has no room
    assign o_busy = i_full;
    assign o_push = i_start & ~i_full;

    // Drop neighbors that lie outside the grid, then take each axis minimum
    always_comb begin
        row_prev = (i_item.row != '0) ? i_item.prev_row_time : egnu_pkg::TIME_MAX;
        col_prev = (i_item.col != '0) ? i_item.prev_col_time : egnu_pkg::TIME_MAX;
        row_min  = row_prev;
        col_min  = col_prev;
        if (i_item.row < i_row_max && i_item.next_row_time < row_prev) begin
            row_min = i_item.next_row_time;
        end
        if (i_item.col < i_col_max && i_item.next_col_time < col_prev) begin
            col_min = i_item.next_col_time;
        end
        o_pair.a = row_min;
        o_pair.b = col_min;
    end

endmodule

// ----- design/egnu_queue.sv -----
// Two-entry queue between the front end and the arithmetic back end.
module egnu_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  egnu_pkg::t_axis_pair  i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic                  o_full,
    output egnu_pkg::t_axis_pair  o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_BITS = $clog2(DEPTH);

    egnu_pkg::t_axis_pair  r_mem [DEPTH];
    logic [PTR_BITS-1:0]   r_wr_ptr;
    logic [PTR_BITS-1:0]   r_rd_ptr;
    logic [PTR_BITS:0]     r_count;
    logic                  do_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (PTR_BITS+1)'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop & o_valid;

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- design/egnu_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, rounded down.
module egnu_sqrt (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic [egnu_pkg::RAD_BITS-1:0]       i_rad,
    input  egnu_pkg::t_side                     i_side,
    output logic                                o_valid,
    output logic [egnu_pkg::ROOT_BITS-1:0]      o_root,
    output egnu_pkg::t_side                     o_side
);

    localparam int NST = egnu_pkg::ROOT_BITS;
    localparam int RB  = egnu_pkg::REM_BITS;
    localparam int QB  = egnu_pkg::ROOT_BITS;
    localparam int NB  = egnu_pkg::RAD_BITS;

    logic              r_valid [NST];
    logic [RB-1:0]     r_rem   [NST];
    logic [QB-1:0]     r_root  [NST];
    logic [NB-1:0]     r_rad   [NST];
    egnu_pkg::t_side   r_side  [NST];

    for (genvar i = 0; i < NST; i++) begin : g_stage
        logic              v_in;
        logic [RB-1:0]     rem_in;
        logic [QB-1:0]     root_in;
        logic [NB-1:0]     rad_in;
        egnu_pkg::t_side   side_in;
        logic [RB+1:0]     cur;
        logic [RB+1:0]     trial;
        logic [RB+1:0]     diff;
        logic              take;

        // Take the previous stage, or the pipeline input at the first stage
        if (i == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_valid[i-1];
            assign rem_in  = r_rem[i-1];
            assign root_in = r_root[i-1];
            assign rad_in  = r_rad[i-1];
            assign side_in = r_side[i-1];
        end

        // Bring down two radicand bits and try the next root bit
        assign cur   = {rem_in, rad_in[NB-1 -: 2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign take  = (cur >= trial);
        assign diff  = cur - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i] <= 1'b0;
            end else begin
                r_valid[i] <= v_in;
            end
        end

        // Remainder never exceeds twice the root, so the top bits drop safely
        always_ff @(posedge i_clk) begin
            r_rem[i]  <= take ? diff[RB-1:0] : cur[RB-1:0];
            r_root[i] <= {root_in[QB-2:0], take};
            r_rad[i]  <= {rad_in[NB-3:0], 2'b00};
            r_side[i] <= side_in;
        end
    end

    assign o_valid = r_valid[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ----- design/egnu_back.sv -----
// Back end: branch choice, radicand, square root and saturation of each item.
module egnu_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  egnu_pkg::t_axis_pair             i_pair,
    input  logic [egnu_pkg::TIME_BITS-1:0]   i_slowness,
    output logic                             o_pop,
    output logic                             o_valid,
    output egnu_pkg::t_node_out              o_result
);

    localparam int TB = egnu_pkg::TIME_BITS;
    localparam int SB = egnu_pkg::SUM_BITS;
    localparam int PB = egnu_pkg::PROD_BITS;
    localparam int NB = egnu_pkg::RAD_BITS;
    localparam int QB = egnu_pkg::ROOT_BITS;

    logic [TB-1:0]        d;
    logic [TB-1:0]        min_ab;
    logic                 quad;
    egnu_pkg::t_side      s1_side;

    logic                 r_s1_valid;
    logic [TB-1:0]        r_s1_d;
    egnu_pkg::t_side      r_s1_side;

    logic                 r_s2_valid;
    logic [PB-1:0]        r_s2_f2;
    logic [PB-1:0]        r_s2_d2;
    egnu_pkg::t_side      r_s2_side;

    logic                 r_s3_valid;
    logic [NB-1:0]        r_s3_rad;
    egnu_pkg::t_side      r_s3_side;

    logic                 sq_valid;
    logic [QB-1:0]        sq_root;
    egnu_pkg::t_side      sq_side;
    logic [SB:0]          quad_sum;
    logic [SB-1:0]        value;

    logic                 r_out_valid;
    egnu_pkg::t_node_out  r_out;
    egnu_pkg::t_node_out  n_out;

    // The pipeline never stalls, so take the queue head whenever present
    assign o_pop = i_valid;

    // Stage 1: axis gap, branch test and the sum that each branch starts from
    always_comb begin
        d      = (i_pair.a > i_pair.b) ? (i_pair.a - i_pair.b) : (i_pair.b - i_pair.a);
        min_ab = (i_pair.a < i_pair.b) ? i_pair.a : i_pair.b;
        quad   = (i_slowness > d);
        s1_side.quad = quad;
        s1_side.base = quad ? ({1'b0, i_pair.a} + {1'b0, i_pair.b})
                            : ({1'b0, i_slowness} + {1'b0, min_ab});
    end

    // Stage 2: squares of slowness and gap
    // Stage 3: radicand 2f^2 - d^2, nonnegative whenever the quadratic branch holds
    always_ff @(posedge i_clk) begin
        r_s1_d    <= d;
        r_s1_side <= s1_side;
        r_s2_f2   <= PB'(i_slowness) * PB'(i_slowness);
        r_s2_d2   <= PB'(r_s1_d) * PB'(r_s1_d);
        r_s2_side <= r_s1_side;
        r_s3_rad  <= {1'b0, r_s2_f2, 1'b0} - {2'b00, r_s2_d2};
        r_s3_side <= r_s2_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    egnu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s3_valid),
        .i_rad   (r_s3_rad),
        .i_side  (r_s3_side),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Finish the quadratic branch, then clip to the largest time code
    always_comb begin
        quad_sum = {1'b0, sq_side.base} + {1'b0, sq_root};
        value    = sq_side.quad ? quad_sum[SB:1] : sq_side.base;
        n_out.two_sided = sq_side.quad;
        n_out.saturated = value[SB-1];
        n_out.new_time  = value[SB-1] ? egnu_pkg::TIME_MAX : value[TB-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= sq_valid;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- design/eikonal_grid_node_update_core.sv -----
// A result strobes once its item has passed the queue, back end stages 1 to 3, the
//   square root pipeline and the output register. Throughput: one item per cycle; the
//   33-stage square root pipeline, one root bit per stage, sets the latency and accepts a
//   new radicand every cycle. The result strobe cannot be held off, so busy stays low in
//   normal operation. Reset (synchronous, active low) empties the queue and pipeline and
//   loads slowness 1.0, row_max 200 and col_max 200.
module eikonal_grid_node_update_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  egnu_pkg::t_node_in                    i_item,
    output logic                                  o_result_valid,
    output egnu_pkg::t_node_out                   o_result,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [egnu_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [egnu_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    logic [egnu_pkg::TIME_BITS-1:0]  r_slowness;
    logic [egnu_pkg::INDEX_BITS-1:0] r_row_max;
    logic [egnu_pkg::INDEX_BITS-1:0] r_col_max;

    logic                  q_full;
    logic                  q_push;
    logic                  q_valid;
    logic                  q_pop;
    egnu_pkg::t_axis_pair  front_pair;
    egnu_pkg::t_axis_pair  q_head;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slowness <= egnu_pkg::SLOWNESS_RST;
            r_row_max  <= egnu_pkg::ROW_MAX_RST;
            r_col_max  <= egnu_pkg::COL_MAX_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                egnu_pkg::CFG_SLOWNESS: r_slowness <= i_cfg_data[egnu_pkg::TIME_BITS-1:0];
                egnu_pkg::CFG_ROW_MAX:  r_row_max  <= i_cfg_data[egnu_pkg::INDEX_BITS-1:0];
                egnu_pkg::CFG_COL_MAX:  r_col_max  <= i_cfg_data[egnu_pkg::INDEX_BITS-1:0];
                default: ;
            endcase
        end
    end

    egnu_front u_front (
        .i_start   (start),
        .i_full    (q_full),
        .i_item    (i_item),
        .i_row_max (r_row_max),
        .i_col_max (r_col_max),
        .o_busy    (busy),
        .o_push    (q_push),
        .o_pair    (front_pair)
    );

    egnu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_pair),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_head)
    );

    egnu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_pair     (q_head),
        .i_slowness (r_slowness),
        .o_pop      (q_pop),
        .o_valid    (o_result_valid),
        .o_result   (o_result)
    );

endmodule

// ----- design/egnu_checker.sv -----
// Port-level checks for the eikonal grid node update core, bound to the top level.
module egnu_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 o_result_valid,
    input  egnu_pkg::t_node_out  o_result,
    input  logic                 o_cfg_ready
);

    // Clock edges from the edge that accepts an item to the edge that takes its result
    localparam int LATENCY = 38;

    // Every result strobe traces back to an item accepted a fixed time earlier
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(start && !busy, LATENCY))
        else $error("result strobe without an accepted item");

    // An accepted item always yields its result after the fixed latency
    a_item_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_result_valid)
        else $error("accepted item produced no result");

    // A clipped result carries the largest time code
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.saturated) |-> (o_result.new_time == egnu_pkg::TIME_MAX))
        else $error("saturated result is not the largest code");

    // Reset leaves no result in flight
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result strobe right after reset");

    // Configuration writes are never refused
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind eikonal_grid_node_update_core egnu_checker u_egnu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_result       (o_result),
    .o_cfg_ready    (o_cfg_ready)
);
